// ===== sv/hpp_pkg.sv =====
// Shared types and constants for the homography point projector.
package hpp_pkg;

    // Exact width of one homogeneous row sum (two 64-bit products plus a shifted coefficient)
    localparam int SUM_W = 66;
    // Quotient bits worked by the divider; anything at or above 2^QB saturates
    localparam int QB = 33;
    // Divider latency: overflow check, one stage per quotient bit, rounding
    localparam int DIV_LAT = QB + 2;

    // Configuration register indexes
    localparam logic [2:0] REG_COEF_PAIR_0 = 3'd0;
    localparam logic [2:0] REG_COEF_PAIR_1 = 3'd1;
    localparam logic [2:0] REG_COEF_PAIR_2 = 3'd2;
    localparam logic [2:0] REG_COEF_PAIR_3 = 3'd3;
    localparam logic [2:0] REG_COEF_LAST   = 3'd4;

    // Identity matrix at reset (1.0 in Q12.20)
    localparam logic [63:0] COEF_PAIR_ONE_ZERO = 64'h0010_0000_0000_0000;
    localparam logic [31:0] COEF_ONE           = 32'h0010_0000;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] src_x;
        logic signed [31:0] src_y;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] dst_x;
        logic signed [31:0] dst_y;
        status_t            status;
    } out_beat_t;

endpackage

// ===== sv/hpp_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
interface hpp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/hpp_div_pipe.sv =====
// Pipelined restoring divider: rounded, saturated 32-bit quotient of magnitudes.
module hpp_div_pipe #(
    parameter int NW = 82
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic [NW-1:0]                  n,
    input  logic [hpp_pkg::SUM_W-1:0]      d,
    input  logic                           neg,
    output logic [31:0]                    q,
    output logic                           sat
);
    localparam int DW = hpp_pkg::SUM_W;
    localparam int QB = hpp_pkg::QB;
    localparam int RW = DW + 1;
    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic [RW-1:0] r_reg   [0:QB];
    logic [QB-1:0] nlo_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic [DW-1:0] d_reg   [0:QB];
    logic          neg_reg [0:QB];
    logic          ovf_reg [0:QB];

    logic [31:0]   q_out_reg;
    logic          sat_out_reg;

    // Entry: quotient of 2^QB or more saturates; else the top bits start the remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= CW'(n) >= (CW'(d) << QB);
            r_reg[0]   <= RW'(n >> QB);
            nlo_reg[0] <= n[QB-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= d;
            neg_reg[0] <= neg;
        end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [RW-1:0] t;
        logic          ge;

        always_comb
        begin
            t  = {r_reg[k][RW-2:0], nlo_reg[k][QB-1]};
            ge = t >= {1'b0, d_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]   <= ge ? (t - {1'b0, d_reg[k]}) : t;
                q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
                nlo_reg[k+1] <= {nlo_reg[k][QB-2:0], 1'b0};
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // Round half away from zero, then clamp to the signed 32-bit range
    logic          half;
    logic [QB:0]   qr;
    logic [QB:0]   lim;
    logic          sat_next;
    logic [31:0]   q_next;

    always_comb
    begin
        half     = {r_reg[QB][RW-2:0], 1'b0} >= {1'b0, d_reg[QB]};
        qr       = {1'b0, q_reg[QB]} + (QB+1)'(half);
        lim      = neg_reg[QB] ? (QB+1)'(hpp_pkg::SAT_NEG) : (QB+1)'(hpp_pkg::SAT_POS);
        sat_next = ovf_reg[QB] || (qr > lim);
        if (sat_next)
        begin
            q_next = neg_reg[QB] ? hpp_pkg::SAT_NEG : hpp_pkg::SAT_POS;
        end
        else
        begin
            q_next = neg_reg[QB] ? (32'd0 - qr[31:0]) : qr[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_out_reg   <= '0;
            sat_out_reg <= 1'b0;
        end
        else if (en)
        begin
            q_out_reg   <= q_next;
            sat_out_reg <= sat_next;
        end
    end

    assign q   = q_out_reg;
    assign sat = sat_out_reg;
endmodule

// ===== sv/homography_point_projector_unit.sv =====
// Top level: streaming projection of Q16.16 points through a 3x3 homography.
//
// Usage: points enter on pt_in (src_x, src_y) and projected points leave on pt_out
// (dst_x, dst_y, status), both valid/ready streams; one result beat per input beat, in order.
// The matrix lives in five registers written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the pipeline is empty (the block does not enforce this).
// Reset loads the identity matrix. Throughput: one point per cycle while pt_out takes
// its beats. Stages: products, row sums, magnitudes, then the divider (overflow check,
// 33 restoring steps, rounding) for x and y in parallel.
// Stall: when pt_out holds a beat that is not taken, the whole pipeline freezes and
// pt_in.ready drops; bubbles move along with their valid bits, nothing is lost.
// Reset clears all valid bits; pt_out.valid is low until the first result arrives.
// Status: 2 when the homogeneous divisor is zero (coordinates 0), 1 when a
// coordinate saturated, else 0.
module homography_point_projector_unit #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hpp_stream_if.sink           pt_in,
    hpp_stream_if.source         pt_out,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data
);
    localparam int SW = hpp_pkg::SUM_W;
    localparam int NW = SW + COORD_FRAC_BITS;
    localparam int DL = hpp_pkg::DIV_LAT;

    // Configuration registers
    logic [63:0] coef_pair_0_reg, coef_pair_1_reg, coef_pair_2_reg, coef_pair_3_reg;
    logic [31:0] coef_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_pair_0_reg <= hpp_pkg::COEF_PAIR_ONE_ZERO;
            coef_pair_1_reg <= '0;
            coef_pair_2_reg <= hpp_pkg::COEF_PAIR_ONE_ZERO;
            coef_pair_3_reg <= '0;
            coef_last_reg   <= hpp_pkg::COEF_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hpp_pkg::REG_COEF_PAIR_0: coef_pair_0_reg <= cfg_data;
                hpp_pkg::REG_COEF_PAIR_1: coef_pair_1_reg <= cfg_data;
                hpp_pkg::REG_COEF_PAIR_2: coef_pair_2_reg <= cfg_data;
                hpp_pkg::REG_COEF_PAIR_3: coef_pair_3_reg <= cfg_data;
                hpp_pkg::REG_COEF_LAST:   coef_last_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
    assign h00 = signed'(coef_pair_0_reg[63:32]);
    assign h01 = signed'(coef_pair_0_reg[31:0]);
    assign h02 = signed'(coef_pair_1_reg[63:32]);
    assign h10 = signed'(coef_pair_1_reg[31:0]);
    assign h11 = signed'(coef_pair_2_reg[63:32]);
    assign h12 = signed'(coef_pair_2_reg[31:0]);
    assign h20 = signed'(coef_pair_3_reg[63:32]);
    assign h21 = signed'(coef_pair_3_reg[31:0]);
    assign h22 = signed'(coef_last_reg);

    // Pipeline advance: move whenever the output slot is empty or being taken
    logic adv;
    logic v1_reg, v2_reg, v3_reg;
    logic vd_reg [0:DL-1];
    logic z_reg  [0:DL-1];

    assign adv         = !vd_reg[DL-1] || pt_out.ready;
    assign pt_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i < DL; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= pt_in.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < DL; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    // Stage 1: six 32x32 products
    logic signed [63:0] p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg <= h00 * pt_in.data.src_x;
            p01_reg <= h01 * pt_in.data.src_y;
            p10_reg <= h10 * pt_in.data.src_x;
            p11_reg <= h11 * pt_in.data.src_y;
            p20_reg <= h20 * pt_in.data.src_x;
            p21_reg <= h21 * pt_in.data.src_y;
        end
    end

    // Stage 2: exact row sums, constant column scaled to the product format
    logic signed [SW-1:0] nx_reg, ny_reg, dn_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg <= SW'(p00_reg) + SW'(p01_reg) + (SW'(h02) <<< COORD_FRAC_BITS);
            ny_reg <= SW'(p10_reg) + SW'(p11_reg) + (SW'(h12) <<< COORD_FRAC_BITS);
            dn_reg <= SW'(p20_reg) + SW'(p21_reg) + (SW'(h22) <<< COORD_FRAC_BITS);
        end
    end

    // Stage 3: magnitudes, result signs and zero divisor
    logic [NW-1:0] nxa_reg, nya_reg;
    logic [SW-1:0] da_reg;
    logic          negx_reg, negy_reg, dz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nxa_reg  <= NW'(nx_reg[SW-1] ? SW'(-nx_reg) : SW'(nx_reg)) << COORD_FRAC_BITS;
            nya_reg  <= NW'(ny_reg[SW-1] ? SW'(-ny_reg) : SW'(ny_reg)) << COORD_FRAC_BITS;
            da_reg   <= dn_reg[SW-1] ? SW'(-dn_reg) : SW'(dn_reg);
            negx_reg <= nx_reg[SW-1] ^ dn_reg[SW-1];
            negy_reg <= ny_reg[SW-1] ^ dn_reg[SW-1];
            dz_reg   <= dn_reg == '0;
        end
    end

    // Zero-divisor flag travels alongside the dividers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_reg[0] <= dz_reg;
            for (int i = 1; i < DL; i++)
            begin
                z_reg[i] <= z_reg[i-1];
            end
        end
    end

    // Dividers for both coordinates
    logic [31:0] qx, qy;
    logic        satx, saty;

    hpp_div_pipe #(.NW(NW)) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .n     (nxa_reg),
        .d     (da_reg),
        .neg   (negx_reg),
        .q     (qx),
        .sat   (satx)
    );

    hpp_div_pipe #(.NW(NW)) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .n     (nya_reg),
        .d     (da_reg),
        .neg   (negy_reg),
        .q     (qy),
        .sat   (saty)
    );

    // Output beat
    always_comb
    begin
        pt_out.valid = vd_reg[DL-1];
        if (z_reg[DL-1])
        begin
            pt_out.data.dst_x  = '0;
            pt_out.data.dst_y  = '0;
            pt_out.data.status = hpp_pkg::ST_DIV0;
        end
        else
        begin
            pt_out.data.dst_x  = signed'(qx);
            pt_out.data.dst_y  = signed'(qy);
            pt_out.data.status = (satx || saty) ? hpp_pkg::ST_SAT : hpp_pkg::ST_OK;
        end
    end

    // Checks
    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pt_out.valid && pt_out.data.status == hpp_pkg::ST_DIV0
            |-> pt_out.data.dst_x == 32'sd0 && pt_out.data.dst_y == 32'sd0)
        else $error("zero divisor beat with nonzero coordinates");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        pt_out.valid && pt_out.data.status == hpp_pkg::ST_SAT
            |-> pt_out.data.dst_x == signed'(hpp_pkg::SAT_POS)
             || pt_out.data.dst_x == signed'(hpp_pkg::SAT_NEG)
             || pt_out.data.dst_y == signed'(hpp_pkg::SAT_POS)
             || pt_out.data.dst_y == signed'(hpp_pkg::SAT_NEG))
        else $error("saturated status without a clamped coordinate");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !pt_in.ready |-> pt_out.valid && !pt_out.ready)
        else $error("input stalled while output slot free");
endmodule
